@@ sv/tdt_pkg.sv @@
// Shared types and constants for the thread deadline tick timer.
// Used by tdt_cell and thread_deadline_tick_timer; depends on nothing else.
package tdt_pkg;

   // Number of threads served; thread k+1 is bit k of every mask.
   localparam int THREAD_COUNT = 32;
   // One cell per thread plus the monitor alarm cell at position 0.
   localparam int CELL_COUNT   = THREAD_COUNT + 1;

   localparam int MASK_W  = 32;
   localparam int TIME_W  = 32;
   localparam int STAMP_W = 64;
   localparam int INDEX_W = 6;
   localparam int INCR_W  = 32;

   localparam int  TICK_RATE_HZ = 1000;
   localparam logic [TIME_W-1:0] SIGN_BIT = 32'h8000_0000;
   // One millisecond as a 32-bit binary fraction of a second.
   localparam logic [63:0] INCR_FULL = 64'h1_0000_0000 / TICK_RATE_HZ;
   localparam logic [INCR_W-1:0] TICK_INCR_RESET = INCR_FULL[INCR_W-1:0];

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_ARM   = 2'd1,
      OP_WAKE  = 2'd2,
      OP_CLEAR = 2'd3
   } tdt_op_type;

   // Configuration register indexes.
   localparam logic CSR_TICK_INCR    = 1'b0;
   localparam logic CSR_ALARM_ENABLE = 1'b1;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } tdt_state_type;

   // Deadline write command broadcast to the cell row.
   typedef struct packed {
      logic              en;
      logic [TIME_W-1:0] data;
   } tdt_cell_wr_type;

endpackage

@@ sv/thread_deadline_tick_timer.sv @@
// Top level of the thread deadline tick timer: sequencer, masks, clock and timestamp.
// Depends on tdt_pkg and a row of tdt_cell instances.
//
// Usage: each request word carries one operation in req_tuser (tick, arm,
// wake, clear) and its operands in req_tdata. Every request produces exactly
// one response word with the millisecond clock, the ready, waiting and woken
// masks, the defer and alarm flags and the 64-bit timestamp after the item.
//
// Timing: a request is taken when the block is idle. In the cycle after the
// accept, the row of deadline cells compares all deadlines in parallel against
// the already advanced clock, and the response is loaded into the output
// register at the end of that cycle if that register is free; rsp_tvalid
// rises with the load. The block takes no new request until the compare
// cycle of the cell row following the update has loaded the response.
//
// Stalls: the output register holds a finished word while the next request
// is taken; if the receiver keeps rsp_tready low, the compare cycle waits
// until the output register can be reloaded, and req_tready stays low.
//
// Reset: clock, timestamp, all deadlines, the wait and ready masks are
// cleared; tick_increment returns to one millisecond (4294967) and the alarm
// compare is enabled. Configuration words are always accepted, and must only
// be sent while no request is in flight.
module thread_deadline_tick_timer
   import tdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: thread_index[5:0], deadline[37:6], thread_mask[69:38], zero pad.
   input  logic [71:0]  req_tdata,
   // tuser from bit 0: op[1:0].
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: clock_ms[31:0], ready_mask[63:32], waiting_mask[95:64],
   // woken_mask[127:96], defer_request[128], alarm_hit[129], timestamp[193:130],
   // zero pad.
   output logic [199:0] rsp_tdata,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);

   // Unpacked request fields.
   tdt_op_type         req_op;
   logic [INDEX_W-1:0] req_index;
   logic [TIME_W-1:0]  req_deadline;
   logic [MASK_W-1:0]  req_mask;

   assign req_op       = tdt_op_type'(req_tuser);
   assign req_index    = req_tdata[5:0];
   assign req_deadline = req_tdata[37:6];
   assign req_mask     = req_tdata[69:38];

   // Configuration registers.
   logic [INCR_W-1:0] tick_incr_ff;
   logic              alarm_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_incr_ff <= TICK_INCR_RESET;
         alarm_en_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TICK_INCR:    tick_incr_ff <= csr_data;
            CSR_ALARM_ENABLE: alarm_en_ff  <= csr_data[0];
            default:          tick_incr_ff <= tick_incr_ff;
         endcase
      end
   end

   // Sequencer: the accept cycle applies clock, arm and clear updates, the
   // evaluation cycle resolves wakeups and loads the response register.
   tdt_state_type state_ff;
   tdt_state_type state_in;
   logic          accept;
   logic          slot_free;
   logic          eval_fire;
   logic          rsp_valid_ff;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EVAL;
         ST_EVAL: if (slot_free)  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      eval_fire  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EVAL: eval_fire  = slot_free;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operation and mask held for the evaluation cycle.
   tdt_op_type        op_ff;
   logic [MASK_W-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         mask_ff <= req_mask;
      end
   end

   // Millisecond clock and timestamp advance at the accept of a tick.
   logic [TIME_W-1:0]  clock_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic               tick_accept;

   assign tick_accept = accept && (req_op == OP_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
         stamp_ff <= '0;
      end else if (tick_accept) begin
         clock_ff <= clock_ff + 1'b1;
         stamp_ff <= stamp_ff + STAMP_W'(tick_incr_ff);
      end
   end

   // Row of deadline cells: cell 0 is the monitor alarm, cell k+1 is thread k+1.
   logic [CELL_COUNT-1:0] due_vec;
   logic                  arm_accept;

   assign arm_accept = accept && (req_op == OP_ARM);

   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      tdt_cell_wr_type wr;
      assign wr.en   = arm_accept && (req_index == INDEX_W'(c));
      assign wr.data = req_deadline;
      tdt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .wr    (wr),
         .now   (clock_ff),
         .due   (due_vec[c])
      );
   end

   // Wait and ready masks, one bit per thread.
   logic [THREAD_COUNT-1:0] wait_ff;
   logic [THREAD_COUNT-1:0] wait_in;
   logic [THREAD_COUNT-1:0] ready_ff;
   logic [THREAD_COUNT-1:0] ready_in;
   logic [THREAD_COUNT-1:0] arm_bits;
   logic [THREAD_COUNT-1:0] woken;
   logic                    alarm;

   for (genvar t = 0; t < THREAD_COUNT; t++) begin : g_arm
      assign arm_bits[t] = arm_accept && (req_index == INDEX_W'(t + 1));
   end

   // Threads woken in the evaluation cycle by a tick or a wake item.
   always_comb begin
      woken = '0;
      alarm = 1'b0;
      case (op_ff)
         OP_TICK: begin
            woken = wait_ff & due_vec[CELL_COUNT-1:1];
            alarm = alarm_en_ff && due_vec[0];
         end
         OP_WAKE: woken = wait_ff & mask_ff[THREAD_COUNT-1:0];
         default: woken = '0;
      endcase
   end

   always_comb begin
      wait_in  = wait_ff;
      ready_in = ready_ff;
      if (accept) begin
         wait_in = wait_ff | arm_bits;
         if (req_op == OP_CLEAR) begin
            ready_in = ready_ff & ~req_mask[THREAD_COUNT-1:0];
         end
      end else if (eval_fire) begin
         wait_in  = wait_ff & ~woken;
         ready_in = ready_ff | woken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff  <= '0;
         ready_ff <= '0;
      end else begin
         wait_ff  <= wait_in;
         ready_ff <= ready_in;
      end
   end

   // Response register.
   logic [199:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eval_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire) begin
         rsp_data_ff <= {6'd0,
                         stamp_ff,
                         alarm,
                         (woken != '0),
                         MASK_W'(woken),
                         MASK_W'(wait_in),
                         MASK_W'(ready_in),
                         clock_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/tdt_cell.sv @@
// One deadline cell: holds a single deadline and flags it due against the clock.
// Depends on tdt_pkg.
module tdt_cell
   import tdt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  tdt_cell_wr_type   wr,
   input  logic [TIME_W-1:0] now,
   output logic              due
);

   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] deadline_in;
   logic [TIME_W-1:0] diff;

   assign deadline_in = wr.en ? wr.data : deadline_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= '0;
      end else begin
         deadline_ff <= deadline_in;
      end
   end

   // Due when the wrap-around difference is zero or negative.
   assign diff = deadline_ff - now;
   assign due  = (diff == '0) || ((diff & SIGN_BIT) != '0);

endmodule

@@ tb/thread_deadline_tick_timer_test.sv @@
// Self-checking testbench for thread_deadline_tick_timer: stimulus, scoreboard and predictor.
// Depends on tdt_pkg and the thread_deadline_tick_timer RTL; reads no files.
module thread_deadline_tick_timer_test;
   import tdt_pkg::*;

   // Threads that exist; bits above THREAD_COUNT in a mask are ignored.
   localparam logic [MASK_W-1:0] THREAD_BITS = 32'hFFFF_FFFF >> (32 - THREAD_COUNT);
   // Cycles with no accepted word on any channel before the run is abandoned.
   localparam int QUIET_LIMIT = 3000;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int LONG_STALL = 90;

   // One request word as the sender sees it.
   typedef struct {
      tdt_op_type         op;
      logic [INDEX_W-1:0] thread_index;
      logic [TIME_W-1:0]  deadline;
      logic [MASK_W-1:0]  thread_mask;
   } timer_cmd_type;

   // One response word, field by field.
   typedef struct {
      logic [TIME_W-1:0]  clock_ms;
      logic [MASK_W-1:0]  ready_mask;
      logic [MASK_W-1:0]  waiting_mask;
      logic [MASK_W-1:0]  woken_mask;
      logic               defer_request;
      logic               alarm_hit;
      logic [STAMP_W-1:0] timestamp;
   } timer_status_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_data = '0;

   thread_deadline_tick_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial forever #5 clock = ~clock;

   // Words still to be sent, and the status words the block owes us.
   timer_cmd_type    pending_cmds[$];
   timer_status_type expected_status[$];
   timer_cmd_type    wire_cmd;

   // Percent of cycles in which each side holds back; changed between phases.
   int sender_idle_pct   = 18;
   int receiver_idle_pct = 55;

   int error_count  = 0;
   int status_count = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   // Clock value the generator expects after the words queued so far. The
   // millisecond clock only moves on ticks, so it is simply the tick count.
   logic [TIME_W-1:0] plan_clock = '0;

   // Predictor state: the scheduler's view of time, deadlines and masks.
   logic [TIME_W-1:0]  model_clock_ms = '0;
   logic [TIME_W-1:0]  model_deadline [CELL_COUNT];
   logic [MASK_W-1:0]  model_waiting = '0;
   logic [MASK_W-1:0]  model_ready = '0;
   logic [STAMP_W-1:0] model_stamp = '0;
   logic [INCR_W-1:0]  model_tick_incr = TICK_INCR_RESET;
   logic               model_alarm_en = 1'b1;

   initial foreach (model_deadline[i]) model_deadline[i] = '0;

   // A deadline is due once the wrap-around distance to it is zero or negative.
   function automatic logic deadline_due(input logic [TIME_W-1:0] when_ms,
                                         input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] diff;
      diff = when_ms - now_ms;
      return diff == '0 || (diff & SIGN_BIT) != '0;
   endfunction

   // Applies one accepted request to the predictor and queues the status word
   // the block must answer with.
   function automatic void compute_status(input timer_cmd_type c);
      timer_status_type s;
      logic [MASK_W-1:0] woken;
      logic alarm;
      woken = '0;
      alarm = 1'b0;
      case (c.op)
         OP_TICK: begin
            model_stamp    = model_stamp + 64'(model_tick_incr);
            model_clock_ms = model_clock_ms + 1;
            for (int k = 0; k < THREAD_COUNT; k++)
               if (model_waiting[k] && deadline_due(model_deadline[k+1], model_clock_ms))
                  woken[k] = 1'b1;
            alarm = model_alarm_en && deadline_due(model_deadline[0], model_clock_ms);
         end
         OP_ARM: begin
            // Entry 0 is the monitor alarm and never waits; indexes past the
            // last thread are dropped.
            if (c.thread_index <= THREAD_COUNT) begin
               model_deadline[c.thread_index] = c.deadline;
               if (c.thread_index != 0)
                  model_waiting[c.thread_index - 1] = 1'b1;
            end
         end
         OP_WAKE: woken = c.thread_mask & model_waiting & THREAD_BITS;
         default: model_ready = model_ready & ~(c.thread_mask & THREAD_BITS);
      endcase
      model_ready   = model_ready | woken;
      model_waiting = model_waiting & ~woken;
      s.clock_ms      = model_clock_ms;
      s.ready_mask    = model_ready;
      s.waiting_mask  = model_waiting;
      s.woken_mask    = woken;
      s.defer_request = woken != '0;
      s.alarm_hit     = alarm;
      s.timestamp     = model_stamp;
      expected_status.push_back(s);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch at status word %0d, %s: got %h, expected %h",
               status_count, what, got, want);
   endtask

   task automatic check_status(input timer_status_type got);
      timer_status_type want;
      if (expected_status.size() == 0) begin
         report_mismatch("word with nothing expected, clock_ms", 64'(got.clock_ms), '0);
         return;
      end
      want = expected_status.pop_front();
      if (got.clock_ms !== want.clock_ms)
         report_mismatch("clock_ms", 64'(got.clock_ms), 64'(want.clock_ms));
      if (got.ready_mask !== want.ready_mask)
         report_mismatch("ready_mask", 64'(got.ready_mask), 64'(want.ready_mask));
      if (got.waiting_mask !== want.waiting_mask)
         report_mismatch("waiting_mask", 64'(got.waiting_mask), 64'(want.waiting_mask));
      if (got.woken_mask !== want.woken_mask)
         report_mismatch("woken_mask", 64'(got.woken_mask), 64'(want.woken_mask));
      if (got.defer_request !== want.defer_request)
         report_mismatch("defer_request", 64'(got.defer_request), 64'(want.defer_request));
      if (got.alarm_hit !== want.alarm_hit)
         report_mismatch("alarm_hit", 64'(got.alarm_hit), 64'(want.alarm_hit));
      if (got.timestamp !== want.timestamp)
         report_mismatch("timestamp", got.timestamp, want.timestamp);
   endtask

   // Queues one request word and keeps the planned clock in step with ticks.
   function automatic void push_cmd(input tdt_op_type op, input logic [INDEX_W-1:0] idx,
                                    input logic [TIME_W-1:0] dl,
                                    input logic [MASK_W-1:0] msk);
      timer_cmd_type c;
      c.op           = op;
      c.thread_index = idx;
      c.deadline     = dl;
      c.thread_mask  = msk;
      pending_cmds.push_back(c);
      if (op == OP_TICK)
         plan_clock = plan_clock + 1;
   endfunction

   // Distance from the planned clock to a new deadline. Half land a few ticks
   // out so threads really wake; the rest are due at once, sit on the half-range
   // boundary of the signed compare, are already overdue, or fall anywhere.
   function automatic logic [TIME_W-1:0] pick_offset();
      case ($urandom_range(9))
         0: return '0;
         1: return -TIME_W'($urandom_range(1, 4));
         2: return 32'h8000_0000;
         3: return 32'h8000_0001;
         4: return $urandom;
         default: return TIME_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Random traffic: mostly arm-then-tick sequences that make deadlines
   // expire, with a wake or a clear now and then, mixed with loose noise
   // words (any op, any index including out of range, any mask).
   function automatic void gen_random_cmds(input int count);
      int stop_at;
      stop_at = pending_cmds.size() + count;
      while (pending_cmds.size() < stop_at) begin
         if ($urandom_range(99) < 65) begin
            repeat ($urandom_range(1, 3))
               push_cmd(OP_ARM, INDEX_W'($urandom_range(1, THREAD_COUNT)),
                        plan_clock + pick_offset(), $urandom);
            if ($urandom_range(3) == 0)
               push_cmd(OP_ARM, '0, plan_clock + pick_offset(), $urandom);
            repeat ($urandom_range(1, 6))
               push_cmd(OP_TICK, INDEX_W'($urandom), $urandom, $urandom);
            if ($urandom_range(3) == 0)
               push_cmd(OP_WAKE, INDEX_W'($urandom), $urandom,
                        ($urandom_range(2) == 0) ? '1 : $urandom);
            if ($urandom_range(1) == 0)
               push_cmd(OP_CLEAR, INDEX_W'($urandom), $urandom,
                        ($urandom_range(2) == 0) ? '1 : $urandom);
         end else begin
            push_cmd(tdt_op_type'(2'($urandom_range(3))), INDEX_W'($urandom_range(63)),
                     $urandom, $urandom);
         end
      end
   endfunction

   // Waits until every queued word has been sent and answered, then gives
   // the block a little margin to settle.
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_status.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes one configuration register; only called while the block is idle,
   // so the predictor can take the new value at the moment of the write.
   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TICK_INCR)
         model_tick_incr = value;
      else
         model_alarm_en = value[0];
   endtask

   // Request driver. A new word is offered only when the wire is free, that
   // is, nothing is up or the word on it is being taken at this edge, so
   // tvalid changes at most once per edge and back-to-back words stay high.
   always @(posedge clock) begin : driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            compute_status(wire_cmd);
         offer = pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct;
         if (offer) begin
            wire_cmd = pending_cmds.pop_front();
            req_tuser <= wire_cmd.op;
            req_tdata <= {2'b00, wire_cmd.thread_mask, wire_cmd.deadline,
                          wire_cmd.thread_index};
         end
         req_tvalid <= offer;
      end
   end

   // Response monitor and receiver. Twice in the run the receiver holds off
   // for a long stretch while the sender keeps offering, so the output
   // register fills and the block has to stall its request side.
   always @(posedge clock) begin : monitor
      timer_status_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.clock_ms      = rsp_tdata[31:0];
            got.ready_mask    = rsp_tdata[63:32];
            got.waiting_mask  = rsp_tdata[95:64];
            got.woken_mask    = rsp_tdata[127:96];
            got.defer_request = rsp_tdata[128];
            got.alarm_hit     = rsp_tdata[129];
            got.timestamp     = rsp_tdata[193:130];
            check_status(got);
            status_count++;
            if (status_count == 120 || status_count == 470)
               stall_left = LONG_STALL;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= receiver_idle_pct;
         end
      end
   end

   // Watchdog: any accepted word on any channel counts as progress.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset configuration. Deadline 0 is zero
      // after reset, so the alarm is already due on the first tick.
      push_cmd(OP_TICK, '0, '0, '0);
      push_cmd(OP_ARM, 6'd1, plan_clock + 2, '0);
      push_cmd(OP_ARM, 6'd32, plan_clock + 1, '0);
      push_cmd(OP_ARM, 6'd0, plan_clock + 20, '0);
      // Indexes past the last thread must change nothing.
      push_cmd(OP_ARM, 6'd33, '0, '1);
      push_cmd(OP_ARM, 6'd63, 32'hFFFF_FFFF, '1);
      push_cmd(OP_WAKE, '0, '0, '0);
      // Thread 32 comes due on the first tick, thread 1 on the second.
      push_cmd(OP_TICK, 6'd63, '1, '1);
      push_cmd(OP_TICK, '0, '0, '0);
      // Re-arming a thread that is ready leaves its ready bit alone; this
      // deadline is long overdue in wrap-around terms.
      push_cmd(OP_ARM, 6'd1, 32'hFFFF_FFFF, '0);
      // Either side of the half-range point: thread 5 stays far in the
      // future, thread 6 wraps round to overdue.
      push_cmd(OP_ARM, 6'd5, plan_clock + 32'h8000_0000, '0);
      push_cmd(OP_ARM, 6'd6, plan_clock + 32'h8000_0001, '0);
      push_cmd(OP_TICK, '0, '0, '0);
      // Waking a thread that is not waiting leaves it untouched, then a full
      // mask wakes thread 5 early.
      push_cmd(OP_WAKE, '0, '0, 32'h0000_0001);
      push_cmd(OP_WAKE, '0, '0, '1);
      push_cmd(OP_CLEAR, '0, '0, 32'h8000_0001);
      push_cmd(OP_CLEAR, '0, '0, '0);
      push_cmd(OP_CLEAR, '0, '0, '1);
      // The alarm is a level: it reports on every tick while it stays due.
      push_cmd(OP_ARM, 6'd0, plan_clock + 1, '0);
      repeat (3) push_cmd(OP_TICK, '0, '0, '0);
      push_cmd(OP_ARM, 6'd0, plan_clock + 32'h4000_0000, '0);
      push_cmd(OP_TICK, '0, '0, '0);
      drain();

      // Largest increment: the seconds field moves on almost every tick.
      write_csr(CSR_TICK_INCR, 32'hFFFF_FFFF);
      write_csr(CSR_ALARM_ENABLE, 1'b1);
      gen_random_cmds(130);
      drain();

      // Frozen timestamp and the alarm compare switched off.
      write_csr(CSR_TICK_INCR, '0);
      write_csr(CSR_ALARM_ENABLE, 1'b0);
      gen_random_cmds(100);
      drain();

      sender_idle_pct   = 55;
      receiver_idle_pct = 18;
      write_csr(CSR_TICK_INCR, $urandom);
      write_csr(CSR_ALARM_ENABLE, 1'b1);
      gen_random_cmds(140);
      drain();

      // Full rate on both sides, back to the one-millisecond increment.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_csr(CSR_TICK_INCR, TICK_INCR_RESET);
      write_csr(CSR_ALARM_ENABLE, 1'b0);
      gen_random_cmds(75);
      drain();
      write_csr(CSR_ALARM_ENABLE, 1'b1);
      gen_random_cmds(75);
      drain();

      repeat (10) @(posedge clock);
      if (expected_status.size() != 0)
         report_mismatch("status words never received", 64'(expected_status.size()), '0);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
